// ----- src/drrip_pkg.sv -----
// Shared constants, row layout and lookup result types for the DRRIP tag store.
// No dependencies; imported by drrip_lookup, drrip_cache_replacement and drrip_checker.
`timescale 1ns / 1ps

package drrip_pkg;

   localparam int ADDR_BITS     = 32;
   localparam int SET_BITS      = 10;
   localparam int WAYS          = 16;
   localparam int OFFSET_BITS   = 6;
   localparam int TAG_BITS      = 16;
   localparam int RRPV_BITS     = 3;
   localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_OUT_BITS  = 4;
   localparam int NSETS         = 1 << SET_BITS;
   localparam int HALF          = SET_BITS / 2;
   localparam int HI_SHIFT      = HALF + (SET_BITS % 2);
   localparam int PSEL_BITS     = 12;
   localparam int THR_BITS      = 8;
   localparam int RW_BITS       = 2;
   localparam int PW_BITS       = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int RSP_BITS      = 24;

   localparam logic [RRPV_BITS-1:0] RRPV_INIT      = '1;
   localparam logic [RW_BITS-1:0]   RRPV_WIDTH_RST = 2'd2;
   localparam logic [THR_BITS-1:0]  THROTTLE_RST   = 8'd31;
   localparam logic [PW_BITS-1:0]   PSEL_WIDTH_RST = 4'd10;
   localparam logic [PW_BITS-1:0]   PSEL_WIDTH_MAX = 4'd12;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RRPV_WIDTH = 2'd0,
      CSR_THROTTLE   = 2'd1,
      CSR_PSEL_WIDTH = 2'd2
   } csr_index_type;

   // One memory row holds a whole set.
   typedef struct packed {
      logic [WAYS-1:0][TAG_BITS-1:0]  tags;
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0][RRPV_BITS-1:0] rrpv;
   } row_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  hit_way;
      logic                 cand;
      logic [WAY_BITS-1:0]  cand_way;
      logic [RRPV_BITS-1:0] top;
      logic [WAY_BITS-1:0]  age_way;
   } lookup_type;

endpackage

// ----- src/drrip_lookup.sv -----
// Parallel tag match, victim search and highest-RRPV search over one set row.
// Depends on drrip_pkg.
`timescale 1ns / 1ps

module drrip_lookup import drrip_pkg::*; (
   input  row_type                row,
   input  logic [TAG_BITS-1:0]    tag,
   input  logic [RRPV_BITS-1:0]   mx,
   output lookup_type             res
);

   logic [WAYS-1:0]      match;
   logic [RRPV_BITS-1:0] top;
   logic                 any;

   // Highest RRPV, one bit at a time from the top; match keeps ways equal to it.
   always_comb begin
      match = '1;
      top   = '0;
      for (int b = RRPV_BITS - 1; b >= 0; b--) begin
         any = 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            any = any | (match[i] & row.rrpv[i][b]);
         end
         top[b] = any;
         for (int i = 0; i < WAYS; i++) begin
            if (row.rrpv[i][b] != any) begin
               match[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      res     = '0;
      res.top = top;
      for (int i = 0; i < WAYS; i++) begin
         if (!res.hit && row.valid[i] && row.tags[i] == tag) begin
            res.hit     = 1'b1;
            res.hit_way = WAY_BITS'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         if (!res.cand && (!row.valid[i] || row.rrpv[i] >= mx)) begin
            res.cand     = 1'b1;
            res.cand_way = WAY_BITS'(i);
         end
      end
      // First way that reaches the maximum after aging by the shortfall.
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            res.age_way = WAY_BITS'(i);
         end
      end
   end

endmodule

// ----- src/drrip_cache_replacement.sv -----
// DRRIP set-associative tag store: one set row per memory entry, read-modify-write per word.
// Each word passes the idle (row read), lookup and update (write-back, response) states.
// One request word is taken at a time: the next is accepted only once the single memory row
// is read, evaluated and written back; a stalled response holds the write-back stage.
// Reset: synchronous; a clearing pass over all 1024 rows (one set row per cycle) follows,
// with req_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module drrip_cache_replacement import drrip_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Request: tdata = address[31:0]; tuser = is_prefetch
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ADDR_BITS-1:0]     req_tdata,
   input  logic                     req_tuser,
   // Response: tdata = hit[0], way[4:1], evicted_valid[5], evicted_tag[21:6],
   // used_srrip[22], zero pad[23]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,
   // Configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_UPD} state_type;

   state_type              state_ff;
   logic [SET_BITS-1:0]    clr_cnt_ff;
   logic [RW_BITS-1:0]     rrpv_width_ff;
   logic [THR_BITS-1:0]    throttle_limit_ff;
   logic [PW_BITS-1:0]     psel_width_ff;
   logic [PSEL_BITS-1:0]   psel_ff, psel_in;
   logic [THR_BITS-1:0]    thr_cnt_ff, thr_cnt_in;
   logic                   rsp_tvalid_ff;
   logic [RSP_BITS-1:0]    rsp_tdata_ff, rsp_tdata_in;

   // Word in flight
   logic [SET_BITS-1:0]    set_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic                   pf_ff;
   row_type                rd_row_ff;
   row_type                row_ff;
   lookup_type             look_ff;
   lookup_type             look;

   row_type                mem [NSETS];
   logic                   mem_we;
   logic [SET_BITS-1:0]    mem_waddr;
   row_type                mem_wdata;
   row_type                new_row;
   row_type                init_row;

   logic                   req_go, upd_go;
   logic [SET_BITS-1:0]    req_set;
   logic [TAG_BITS-1:0]    req_tag;
   logic [RW_BITS-1:0]     rw;
   logic [RRPV_BITS-1:0]   mx, gap;
   logic [PW_BITS-1:0]     pw;
   logic [PSEL_BITS-1:0]   pmx, pcnt;
   logic [HALF-1:0]        lo, hi;
   logic [HALF:0]          lohi_sum;
   logic                   duel_sr, duel_br, srrip, near;
   logic [WAY_BITS-1:0]    victim;
   logic                   ev_valid;
   logic [TAG_BITS-1:0]    ev_tag;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign upd_go     = (state_ff == ST_UPD) && (!rsp_tvalid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign req_set = SET_BITS'(req_tdata >> OFFSET_BITS);
   assign req_tag = TAG_BITS'(req_tdata >> (OFFSET_BITS + SET_BITS));

   // Zero width reads as one; clamp the counter width to 1..12.
   always_comb begin
      rw = (rrpv_width_ff == '0) ? RW_BITS'(1) : rrpv_width_ff;
      mx = RRPV_BITS'((4'd1 << rw) - 4'd1);
      pw = psel_width_ff;
      if (pw == '0) begin
         pw = PW_BITS'(1);
      end else if (pw > PSEL_WIDTH_MAX) begin
         pw = PSEL_WIDTH_MAX;
      end
      pmx  = PSEL_BITS'((13'd1 << pw) - 13'd1);
      pcnt = (psel_ff > pmx) ? pmx : psel_ff;
   end

   drrip_lookup u_lookup (
      .row (rd_row_ff),
      .tag (tag_ff),
      .mx  (mx),
      .res (look)
   );

   // Set dueling: equal halves lead SRRIP, complementary halves lead BRRIP.
   always_comb begin
      lo       = set_ff[HALF-1:0];
      hi       = HALF'(set_ff >> HI_SHIFT);
      lohi_sum = {1'b0, lo} + {1'b0, hi};
      duel_sr  = (lo == hi);
      duel_br  = !duel_sr && (lohi_sum == {1'b0, {HALF{1'b1}}});
      if (duel_sr) begin
         srrip = 1'b1;
      end else if (duel_br) begin
         srrip = 1'b0;
      end else begin
         srrip = pcnt < (pmx >> 1);
      end
      near = (thr_cnt_ff == throttle_limit_ff) || srrip;
   end

   // Row update, counters and response for the word in the update stage.
   always_comb begin
      victim     = look_ff.cand ? look_ff.cand_way : look_ff.age_way;
      gap        = mx - look_ff.top;
      new_row    = row_ff;
      psel_in    = psel_ff;
      thr_cnt_in = thr_cnt_ff;
      ev_valid   = 1'b0;
      ev_tag     = '0;
      if (look_ff.hit) begin
         if (!pf_ff) begin
            new_row.rrpv[look_ff.hit_way] = '0;
         end
         rsp_tdata_in = {1'b0, 1'b0, {TAG_BITS{1'b0}}, 1'b0,
                         WAY_OUT_BITS'(look_ff.hit_way), 1'b1};
      end else begin
         if (!look_ff.cand) begin
            for (int i = 0; i < WAYS; i++) begin
               new_row.rrpv[i] = row_ff.rrpv[i] + gap;
            end
         end
         ev_valid = row_ff.valid[victim];
         ev_tag   = ev_valid ? row_ff.tags[victim] : '0;
         new_row.tags[victim]  = tag_ff;
         new_row.valid[victim] = 1'b1;
         new_row.rrpv[victim]  = near ? (mx - RRPV_BITS'(1)) : mx;
         if (duel_sr) begin
            psel_in = (pcnt < pmx) ? pcnt + PSEL_BITS'(1) : pcnt;
         end else if (duel_br) begin
            psel_in = (pcnt != '0) ? pcnt - PSEL_BITS'(1) : pcnt;
         end else begin
            psel_in = pcnt;
         end
         thr_cnt_in = (thr_cnt_ff == throttle_limit_ff) ? '0 : thr_cnt_ff + THR_BITS'(1);
         rsp_tdata_in = {1'b0, srrip, ev_tag, ev_valid, WAY_OUT_BITS'(victim), 1'b0};
      end
   end

   always_comb begin
      init_row.tags  = '0;
      init_row.valid = '0;
      for (int i = 0; i < WAYS; i++) begin
         init_row.rrpv[i] = RRPV_INIT;
      end
   end

   // Write port: clearing sweep, else write-back on leaving the update stage.
   // A prefetch hit leaves the row untouched.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = new_row;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = init_row;
      end else if (upd_go && !(look_ff.hit && pf_ff)) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_go) begin
         rd_row_ff <= mem[req_set];
      end
   end

   // Payload of the word in flight
   always_ff @(posedge clock) begin
      if (req_go) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
         pf_ff  <= req_tuser;
      end
      if (state_ff == ST_LOOK) begin
         row_ff  <= rd_row_ff;
         look_ff <= look;
      end
   end

   // Control state, counters, configuration and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_cnt_ff        <= '0;
         rrpv_width_ff     <= RRPV_WIDTH_RST;
         throttle_limit_ff <= THROTTLE_RST;
         psel_width_ff     <= PSEL_WIDTH_RST;
         psel_ff           <= '0;
         thr_cnt_ff        <= '0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RRPV_WIDTH: rrpv_width_ff     <= csr_data[RW_BITS-1:0];
               CSR_THROTTLE:   throttle_limit_ff <= csr_data[THR_BITS-1:0];
               CSR_PSEL_WIDTH: psel_width_ff     <= csr_data[PW_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + SET_BITS'(1);
               if (clr_cnt_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_go) begin
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               // Hold here while the previous response is still waiting.
               if (upd_go) begin
                  state_ff      <= ST_IDLE;
                  psel_ff       <= psel_in;
                  thr_cnt_ff    <= thr_cnt_in;
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= rsp_tdata_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- src/drrip_checker.sv -----
// Port-level checks on drrip_cache_replacement, attached by bind.
// Depends on drrip_pkg and drrip_cache_replacement.
`timescale 1ns / 1ps

module drrip_checker import drrip_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_BITS-1:0]      rsp_tdata
);

   // Clearing pass blocks requests right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // One word at a time: no request taken in the cycle after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response word changed");

   // A hit never reports an eviction or a fill policy.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[23:5] == '0))
      else $error("hit word carries eviction fields");

   a_evict_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[5]) |-> (rsp_tdata[21:6] == '0))
      else $error("eviction tag without a valid eviction");

endmodule

bind drrip_cache_replacement drrip_checker u_drrip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the DRRIP tag store: directed accesses, random config phases and
// a long response hold-off. Depends on drrip_pkg and drrip_cache_replacement.
`timescale 1ns / 1ps

module tb_top;
   import drrip_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;   // settle wait after the last owed response is taken
   localparam int HMASK = (1 << HALF) - 1;

   typedef enum int {SET_FOLLOWER, SET_LEADER_SRRIP, SET_LEADER_BRRIP} set_role_type;

   // One response word, split into its fields.
   typedef struct packed {
      logic                hit;
      logic [3:0]          way;
      logic                evicted_valid;
      logic [TAG_BITS-1:0] evicted_tag;
      logic                used_srrip;
   } access_outcome_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ADDR_BITS-1:0]     req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index = CSR_RRPV_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   drrip_cache_replacement u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow tag store: what the block should hold after every word
   // ------------------------------------------------------------------
   logic [TAG_BITS-1:0]  line_tag   [NSETS][WAYS];
   bit                   line_valid [NSETS][WAYS];
   logic [RRPV_BITS-1:0] line_rrpv  [NSETS][WAYS];
   int unsigned          psel_count;
   logic [THR_BITS-1:0]  fill_count;
   logic [RW_BITS-1:0]   rrpv_width_cfg;
   logic [THR_BITS-1:0]  throttle_cfg;
   logic [PW_BITS-1:0]   psel_width_cfg;

   access_outcome_type access_outcomes[$];   // outcomes still owed by the block, oldest first
   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;                     // response hold-off, counted down by the receiver

   // Pools that keep random traffic concentrated so sets fill, hit and evict.
   logic [SET_BITS-1:0] set_pool [8];
   logic [TAG_BITS-1:0] tag_pool [24];

   function automatic set_role_type role_of(logic [SET_BITS-1:0] s);
      int unsigned lo, hi;
      lo = s & HMASK;
      hi = 32'(s >> HI_SHIFT);
      if (lo == hi) return SET_LEADER_SRRIP;
      if (lo + hi == HMASK) return SET_LEADER_BRRIP;
      return SET_FOLLOWER;
   endfunction

   // Look one access up in the shadow store, update it and return the outcome.
   function automatic access_outcome_type drrip_access(logic [ADDR_BITS-1:0] addr, logic pf);
      logic [SET_BITS-1:0] s;
      logic [TAG_BITS-1:0] t;
      set_role_type role;
      int unsigned rmax, pmax, top, gap, victim, w;
      bit found, srrip;
      access_outcome_type res;
      res = '0;
      s = addr[OFFSET_BITS +: SET_BITS];
      t = addr[OFFSET_BITS + SET_BITS +: TAG_BITS];
      role = role_of(s);
      rmax = (1 << ((rrpv_width_cfg == 0) ? 1 : rrpv_width_cfg)) - 1;
      w = (psel_width_cfg == 0) ? 1 : ((psel_width_cfg > PSEL_WIDTH_MAX) ? PSEL_WIDTH_MAX
                                                                       : psel_width_cfg);
      pmax = (1 << w) - 1;

      for (w = 0; w < WAYS; w++) begin
         if (line_valid[s][w] && line_tag[s][w] == t) begin
            res.hit = 1'b1;
            res.way = w[3:0];
            // prefetch hits leave the line's age alone
            if (!pf) line_rrpv[s][w] = '0;
            return res;
         end
      end

      // victim: first invalid way or first way at (or above) the maximum age
      found = 1'b0;
      victim = 0;
      top = 0;
      for (w = 0; w < WAYS && !found; w++) begin
         if (!line_valid[s][w] || line_rrpv[s][w] >= rmax) begin
            victim = w;
            found = 1'b1;
         end else if (line_rrpv[s][w] > top) begin
            top = 32'(line_rrpv[s][w]);
         end
      end
      if (!found) begin
         // age the whole set by the shortfall of its oldest line
         gap = rmax - top;
         for (w = 0; w < WAYS; w++) begin
            line_rrpv[s][w] = line_rrpv[s][w] + gap[RRPV_BITS-1:0];
            if (!found && line_rrpv[s][w] >= rmax) begin
               victim = w;
               found = 1'b1;
            end
         end
      end

      if (line_valid[s][victim]) begin
         res.evicted_valid = 1'b1;
         res.evicted_tag = line_tag[s][victim];
      end

      if (psel_count > pmax) psel_count = pmax;
      case (role)
         SET_LEADER_SRRIP: begin
            if (psel_count < pmax) psel_count++;
            srrip = 1'b1;
         end
         SET_LEADER_BRRIP: begin
            if (psel_count > 0) psel_count--;
            srrip = 1'b0;
         end
         default: begin
            srrip = psel_count < pmax / 2;
         end
      endcase

      line_tag[s][victim] = t;
      line_valid[s][victim] = 1'b1;
      if (fill_count == throttle_cfg || srrip) begin
         line_rrpv[s][victim] = RRPV_BITS'(rmax - 1);
         fill_count = (fill_count == throttle_cfg) ? '0 : fill_count + 1'b1;
      end else begin
         line_rrpv[s][victim] = RRPV_BITS'(rmax);
         fill_count = fill_count + 1'b1;
      end

      res.way = victim[3:0];
      res.used_srrip = srrip;
      return res;
   endfunction

   task automatic reset_shadow();
      for (int s = 0; s < NSETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            line_valid[s][w] = 1'b0;
            line_rrpv[s][w] = RRPV_INIT;
            line_tag[s][w] = '0;
         end
      end
      psel_count = 0;
      fill_count = '0;
      rrpv_width_cfg = RRPV_WIDTH_RST;
      throttle_cfg = THROTTLE_RST;
      psel_width_cfg = PSEL_WIDTH_RST;
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one word and hold it until taken. tvalid stays high on return so
   // back-to-back words need no low/high pair in one step; drop it via drain.
   task automatic send_access(logic [ADDR_BITS-1:0] addr, logic pf);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= addr;
      req_tuser <= pf;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      access_outcomes.push_back(drrip_access(addr, pf));
   endtask

   // Drop tvalid, wait for every owed response, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (access_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers while the block is idle.
   task automatic apply_config(logic [RW_BITS-1:0] rw, logic [THR_BITS-1:0] thr,
                               logic [PW_BITS-1:0] pw);
      csr_index_type idx;
      logic [CSR_DATA_BITS-1:0] val;
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: begin idx = CSR_RRPV_WIDTH; val = CSR_DATA_BITS'(rw); end
            1: begin idx = CSR_THROTTLE;   val = CSR_DATA_BITS'(thr); end
            default: begin idx = CSR_PSEL_WIDTH; val = CSR_DATA_BITS'(pw); end
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= val;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      rrpv_width_cfg = rw;
      throttle_cfg = thr;
      psel_width_cfg = pw;
   endtask

   function automatic logic [ADDR_BITS-1:0] make_addr(logic [TAG_BITS-1:0] t,
                                                      logic [SET_BITS-1:0] s,
                                                      logic [OFFSET_BITS-1:0] off);
      return {t, s, off};
   endfunction

   task automatic build_pools();
      int unsigned x;
      logic [SET_BITS-1:0] s;
      for (int i = 0; i < 3; i++) begin
         x = $urandom_range(HMASK);
         set_pool[i] = SET_BITS'((x << HI_SHIFT) | x);
         set_pool[i + 3] = SET_BITS'(((HMASK - x) << HI_SHIFT) | x);
      end
      for (int i = 6; i < 8; i++) begin
         do s = SET_BITS'($urandom_range(NSETS - 1)); while (role_of(s) != SET_FOLLOWER);
         set_pool[i] = s;
      end
      foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom_range(16'hFFFF));
   endtask

   // Mostly pooled sets and tags with random offsets; a tenth fully random words.
   task automatic send_random(int count);
      logic [ADDR_BITS-1:0] addr;
      logic pf;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10) begin
            addr = $urandom;
            pf = 1'($urandom_range(1));
         end else begin
            addr = make_addr(tag_pool[$urandom_range(23)], set_pool[$urandom_range(7)],
                             OFFSET_BITS'($urandom));
            pf = ($urandom_range(99) < 25);
         end
         send_access(addr, pf);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   // Random stalls, overridden by a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted response word with the oldest owed outcome.
   always @(posedge clock) begin
      access_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (access_outcomes.size() == 0) begin
            $error("response word %h arrived with nothing outstanding", rsp_tdata);
            errors++;
         end else begin
            want = access_outcomes.pop_front();
            if (rsp_tdata[0] !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[4:1] !== want.way) begin
               $error("way: expected %0d, got %0d", want.way, rsp_tdata[4:1]);
               errors++;
            end
            if (rsp_tdata[5] !== want.evicted_valid) begin
               $error("evicted_valid: expected %0d, got %0d", want.evicted_valid, rsp_tdata[5]);
               errors++;
            end
            if (rsp_tdata[21:6] !== want.evicted_tag) begin
               $error("evicted_tag: expected %h, got %h", want.evicted_tag, rsp_tdata[21:6]);
               errors++;
            end
            if (rsp_tdata[22] !== want.used_srrip) begin
               $error("used_srrip: expected %0d, got %0d", want.used_srrip, rsp_tdata[22]);
               errors++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Address extremes, demand and prefetch hits and misses, each kind of set.
   task automatic test_basic_accesses();
      send_access(32'h0000_0000, 1'b0);                             // leader miss, fill
      send_access(32'h0000_0000, 1'b0);                             // demand hit
      send_access(32'h0000_003F, 1'b1);                             // prefetch hit, no update
      send_access(32'hFFFF_FFFF, 1'b1);                             // prefetch miss, top set
      send_access(32'hFFFF_FFC0, 1'b0);                             // demand hit on that line
      send_access(make_addr(16'h1234, SET_BITS'(HMASK << HI_SHIFT), '0), 1'b0); // bimodal leader
      send_access(make_addr(16'hABCD, 10'h001, 6'h15), 1'b0);       // follower miss
      send_access(make_addr(16'h5555, 10'h002, 6'h2A), 1'b1);       // follower prefetch miss
   endtask

   // Fill every way of a static leader set, then miss once more so the set ages.
   task automatic test_set_aging();
      logic [SET_BITS-1:0] s;
      s = SET_BITS'((1 << HI_SHIFT) | 1);
      for (int w = 0; w <= WAYS; w++) begin
         send_access(make_addr(TAG_BITS'(16'h0100 + w), s, '0), 1'b0);
      end
   endtask

   // Random traffic under one register setting and one idling mix.
   task automatic run_phase(logic [RW_BITS-1:0] rw, logic [THR_BITS-1:0] thr,
                            logic [PW_BITS-1:0] pw, int idle_pct, int stall_pct, int count);
      drain();
      apply_config(rw, thr, pw);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      send_random(count);
   endtask

   // Settings walk through the extremes; lowering widths leaves ages and the
   // policy counter above their new maximum, and a small throttle limit leaves
   // the fill count above it.
   task automatic test_config_sweep();
      run_phase(2'd2, 8'd31,  4'd10, 0,  0,  112);
      run_phase(2'd3, 8'd0,   4'd1,  51, 0,  112);
      run_phase(2'd1, 8'd255, 4'd12, 0,  51, 112);
      run_phase(2'd0, 8'd3,   4'd0,  14, 14, 112);
      run_phase(2'd3, 8'd7,   4'd15, 0,  0,  112);
      run_phase(2'd1, 8'd1,   4'd2,  51, 0,  112);
      run_phase(2'd2, 8'd0,   4'd13, 0,  51, 112);
      run_phase(RW_BITS'($urandom_range(3)), THR_BITS'($urandom_range(255)),
                PW_BITS'($urandom_range(15)), 14, 14, 112);
   endtask

   // Hold the response side off for a long stretch while words keep coming,
   // so the block backs up and stalls its request side.
   task automatic test_backpressure();
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 300;
      send_random(24);
   endtask

   initial begin
      reset_shadow();
      build_pools();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // the block clears its rows after reset; senders just wait for tready
      test_basic_accesses();
      test_set_aging();
      test_config_sweep();
      test_backpressure();
      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- drrip_cache_replacement.f -----
src/drrip_pkg.sv
src/drrip_lookup.sv
src/drrip_cache_replacement.sv
src/drrip_checker.sv
tb/sv/tb_top.sv
